### src/hidt_pkg.sv
`timescale 1ns / 1ps
// Shared constants, codes and helpers for the hashed id handler table.
// No dependencies; used by the top level and its checker.
package hidt_pkg;

   // Table geometry
   localparam int SLOTS  = 64;
   localparam int SLOT_W = $clog2(SLOTS);
   localparam int CNT_W  = $clog2(SLOTS + 1);
   localparam int IDX_W  = 6;

   // Field widths
   localparam int OP_W   = 2;
   localparam int KEY_W  = 32;
   localparam int HND_W  = 32;
   localparam int STAT_W = 2;

   // Hash mixing constants
   localparam logic [KEY_W-1:0] MIX_MULT  = 32'h045d_9f3b;
   localparam int               MIX_SHIFT = 16;

   // Operation codes
   localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
   localparam logic [OP_W-1:0] OP_LOOKUP = 2'd1;
   localparam logic [OP_W-1:0] OP_DELETE = 2'd2;

   // Status codes
   localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
   localparam logic [STAT_W-1:0] ST_NOT_FOUND = 2'd1;
   localparam logic [STAT_W-1:0] ST_FULL      = 2'd2;

   // One xor-shift step of the mix
   function automatic logic [KEY_W-1:0] xor_shift(input logic [KEY_W-1:0] x);
      return x ^ (x >> MIX_SHIFT);
   endfunction

   // Slot number to the reported index: low bits only, zero-extended if narrower
   function automatic logic [IDX_W-1:0] to_index(input logic [SLOT_W-1:0] s);
      logic [IDX_W+SLOT_W-1:0] ext;
      ext = {{IDX_W{1'b0}}, s};
      return ext[IDX_W-1:0];
   endfunction

   // Linear probe step with wraparound
   function automatic logic [SLOT_W-1:0] next_slot(input logic [SLOT_W-1:0] s);
      return (s == SLOT_W'(SLOTS - 1)) ? '0 : s + SLOT_W'(1);
   endfunction

endpackage

### src/hashed_id_handler_table.sv
`timescale 1ns / 1ps
// Top level of the hashed id handler table: hash unit, probe sequencer,
// slot memory and valid bits. Depends on hidt_pkg.
//
// Maps a 32-bit message id to a 32-bit handler tag in a table of SLOTS slots
// with linear probing from a hashed home slot. One request at a time: the hash
// runs through two registered 32x32 multiplies, then the sequencer probes
// one slot per cycle through the key/handler memory, whose read data arrives
// in the cycle after the address. Insert stops at the first free slot and lookup
// at the first matching slot; delete and any miss scan all SLOTS slots.
// The response sits in an output register, so a new request is taken while
// the previous response is still stalled. Valid bits are flops cleared by
// reset; there is no clearing pass.
module hashed_id_handler_table (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [hidt_pkg::OP_W-1:0]     req_operation,
   input  logic [hidt_pkg::KEY_W-1:0]    req_key,
   input  logic [hidt_pkg::HND_W-1:0]    req_handler_in,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [hidt_pkg::STAT_W-1:0]   rsp_status,
   output logic [hidt_pkg::HND_W-1:0]    rsp_handler_out,
   output logic [hidt_pkg::IDX_W-1:0]    rsp_slot_index
);
   import hidt_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE, S_MIX1, S_MIX2, S_MIX3, S_PROBE, S_OUT
   } state_type;

   state_type           state_ff, state_in;
   logic [OP_W-1:0]     op_ff, op_in;
   logic [KEY_W-1:0]    key_ff, key_in;
   logic [HND_W-1:0]    hin_ff, hin_in;
   logic [KEY_W-1:0]    x_ff, x_in;
   logic [SLOT_W-1:0]   addr_ff, addr_in;
   logic [CNT_W-1:0]    iss_ff, iss_in;
   logic                p1_vld_ff, p1_vld_in;
   logic [SLOT_W-1:0]   p1_slot_ff, p1_slot_in;
   logic                hit_ff, hit_in;
   logic [SLOT_W-1:0]   first_ff, first_in;
   logic [STAT_W-1:0]   res_status_ff, res_status_in;
   logic [HND_W-1:0]    res_hnd_ff, res_hnd_in;
   logic [IDX_W-1:0]    res_idx_ff, res_idx_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [STAT_W-1:0]   rsp_status_ff, rsp_status_in;
   logic [HND_W-1:0]    rsp_hnd_ff, rsp_hnd_in;
   logic [IDX_W-1:0]    rsp_idx_ff, rsp_idx_in;
   logic [SLOTS-1:0]    valid_ff, valid_in;

   // Slot memory: {key, handler}
   logic [KEY_W+HND_W-1:0] mem [SLOTS];
   logic [KEY_W+HND_W-1:0] rd_data_ff;
   logic                   rd_en;
   logic                   wr_en;
   logic [SLOT_W-1:0]      wr_addr;

   logic                req_take;
   logic                out_free;
   logic                cur_valid;
   logic                cur_match;
   logic                last_probe;
   logic [KEY_W-1:0]    rd_key;
   logic [HND_W-1:0]    rd_hnd;

   assign req_take  = req_valid && !req_stall;
   assign req_stall = (state_ff != S_IDLE);
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   assign rd_key     = rd_data_ff[KEY_W+HND_W-1:HND_W];
   assign rd_hnd     = rd_data_ff[HND_W-1:0];
   assign cur_valid  = valid_ff[p1_slot_ff];
   assign cur_match  = cur_valid && (rd_key == key_ff);
   assign last_probe = p1_vld_ff && (iss_ff == CNT_W'(SLOTS));
   assign wr_addr    = p1_slot_ff;

   // Sequencer next-state logic
   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      key_in        = key_ff;
      hin_in        = hin_ff;
      x_in          = x_ff;
      addr_in       = addr_ff;
      iss_in        = iss_ff;
      p1_vld_in     = 1'b0;
      p1_slot_in    = p1_slot_ff;
      hit_in        = hit_ff;
      first_in      = first_ff;
      res_status_in = res_status_ff;
      res_hnd_in    = res_hnd_ff;
      res_idx_in    = res_idx_ff;
      valid_in      = valid_ff;
      rd_en         = 1'b0;
      wr_en         = 1'b0;

      case (state_ff)
         S_IDLE: begin
            if (req_take) begin
               op_in    = req_operation;
               key_in   = req_key;
               hin_in   = req_handler_in;
               x_in     = xor_shift(req_key);
               state_in = S_MIX1;
            end
         end
         S_MIX1: begin
            x_in     = x_ff * MIX_MULT;
            state_in = S_MIX2;
         end
         S_MIX2: begin
            x_in     = xor_shift(x_ff) * MIX_MULT;
            state_in = S_MIX3;
         end
         S_MIX3: begin
            addr_in  = SLOT_W'(xor_shift(x_ff) % SLOTS);
            iss_in   = '0;
            hit_in   = 1'b0;
            first_in = '0;
            state_in = S_PROBE;
         end
         S_PROBE: begin
            // Issue one memory read per cycle
            if (iss_ff != CNT_W'(SLOTS)) begin
               rd_en      = 1'b1;
               p1_vld_in  = 1'b1;
               p1_slot_in = addr_ff;
               addr_in    = next_slot(addr_ff);
               iss_in     = iss_ff + CNT_W'(1);
            end
            // Check the slot whose data just came back
            if (p1_vld_ff) begin
               case (op_ff)
                  OP_INSERT: begin
                     if (!cur_valid) begin
                        wr_en                = 1'b1;
                        valid_in[p1_slot_ff] = 1'b1;
                        res_status_in        = ST_OK;
                        res_hnd_in           = '0;
                        res_idx_in           = to_index(p1_slot_ff);
                        state_in             = S_OUT;
                     end else if (last_probe) begin
                        res_status_in = ST_FULL;
                        res_hnd_in    = '0;
                        res_idx_in    = '0;
                        state_in      = S_OUT;
                     end
                  end
                  OP_LOOKUP: begin
                     if (cur_match) begin
                        res_status_in = ST_OK;
                        res_hnd_in    = rd_hnd;
                        res_idx_in    = to_index(p1_slot_ff);
                        state_in      = S_OUT;
                     end else if (last_probe) begin
                        res_status_in = ST_NOT_FOUND;
                        res_hnd_in    = '0;
                        res_idx_in    = '0;
                        state_in      = S_OUT;
                     end
                  end
                  OP_DELETE: begin
                     if (cur_match) begin
                        valid_in[p1_slot_ff] = 1'b0;
                        if (!hit_ff) begin
                           hit_in   = 1'b1;
                           first_in = p1_slot_ff;
                        end
                     end
                     if (last_probe) begin
                        res_hnd_in = '0;
                        if (hit_ff) begin
                           res_status_in = ST_OK;
                           res_idx_in    = to_index(first_ff);
                        end else if (cur_match) begin
                           res_status_in = ST_OK;
                           res_idx_in    = to_index(p1_slot_ff);
                        end else begin
                           res_status_in = ST_NOT_FOUND;
                           res_idx_in    = '0;
                        end
                        state_in = S_OUT;
                     end
                  end
                  default: begin
                     if (last_probe) begin
                        res_status_in = ST_NOT_FOUND;
                        res_hnd_in    = '0;
                        res_idx_in    = '0;
                        state_in      = S_OUT;
                     end
                  end
               endcase
            end
            // A finished probe drops the read still in flight
            if (state_in == S_OUT) begin
               p1_vld_in = 1'b0;
            end
         end
         S_OUT: begin
            if (out_free) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Output register
   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_status_in = rsp_status_ff;
      rsp_hnd_in    = rsp_hnd_ff;
      rsp_idx_in    = rsp_idx_ff;
      if (state_ff == S_OUT && out_free) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = res_status_ff;
         rsp_hnd_in    = res_hnd_ff;
         rsp_idx_in    = res_idx_ff;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   // State and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         p1_vld_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
         valid_ff     <= '0;
      end else begin
         state_ff     <= state_in;
         p1_vld_ff    <= p1_vld_in;
         rsp_valid_ff <= rsp_valid_in;
         valid_ff     <= valid_in;
      end
      op_ff         <= op_in;
      key_ff        <= key_in;
      hin_ff        <= hin_in;
      x_ff          <= x_in;
      addr_ff       <= addr_in;
      iss_ff        <= iss_in;
      p1_slot_ff    <= p1_slot_in;
      hit_ff        <= hit_in;
      first_ff      <= first_in;
      res_status_ff <= res_status_in;
      res_hnd_ff    <= res_hnd_in;
      res_idx_ff    <= res_idx_in;
      rsp_status_ff <= rsp_status_in;
      rsp_hnd_ff    <= rsp_hnd_in;
      rsp_idx_ff    <= rsp_idx_in;
   end

   // Key/handler memory, one write and one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= {key_ff, hin_ff};
      end
      if (rd_en) begin
         rd_data_ff <= mem[addr_ff];
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_handler_out = rsp_hnd_ff;
   assign rsp_slot_index  = rsp_idx_ff;

endmodule

### src/hidt_checker.sv
`timescale 1ns / 1ps
// Port-level checker for the hashed id handler table, bound to the top level.
// Depends on hidt_pkg.
module hidt_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_stall,
   input logic [hidt_pkg::OP_W-1:0]     req_operation,
   input logic [hidt_pkg::KEY_W-1:0]    req_key,
   input logic [hidt_pkg::HND_W-1:0]    req_handler_in,
   input logic                          rsp_valid,
   input logic                          rsp_stall,
   input logic [hidt_pkg::STAT_W-1:0]   rsp_status,
   input logic [hidt_pkg::HND_W-1:0]    rsp_handler_out,
   input logic [hidt_pkg::IDX_W-1:0]    rsp_slot_index
);
   import hidt_pkg::*;

   // A stalled response holds its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_status)
         && $stable(rsp_handler_out) && $stable(rsp_slot_index))
      else $error("stalled response changed");

   // Misses and full inserts carry no handler and no slot
   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != ST_OK |-> rsp_handler_out == '0 && rsp_slot_index == '0)
      else $error("failed request returned nonzero fields");

   // One request at a time: busy right after a request is taken
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("second request taken while busy");

   // Spot check: no response rises while the hash of a taken request runs
   a_latency: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && !(rsp_valid && rsp_stall) |=> ##1 !$rose(rsp_valid))
      else $error("response too early");

   // Nothing is reported straight out of reset
   a_reset: assert property (@(posedge clock)
      !reset && $past(reset) |-> !rsp_valid)
      else $error("response valid after reset");

endmodule

bind hashed_id_handler_table hidt_checker u_hidt_checker (.*);
